>>> sv/rsig_pkg.sv
`timescale 1ns / 1ps
// Package for the rough sigmoid activation block.
// Holds transaction types, fixed-point constants and divider sizing; no dependencies.
package rsig_pkg;

  typedef struct packed {
    logic signed [15:0] sample_in;
    logic               last_in;
  } in_t;

  typedef struct packed {
    logic [15:0] sigmoid_out;
    logic        last_out;
  } out_t;

  typedef struct packed {
    logic [29:0] s;
    logic        pos;
    logic        last;
  } ser_t;

  localparam int DIV_STAGES = 9;
  localparam int DIV_STEPS  = 2;
  localparam int Q_W        = DIV_STAGES * DIV_STEPS;

  typedef struct packed {
    logic [Q_W-1:0] q;
    logic           last;
  } quot_t;

  localparam logic [15:0] COEF_A     = 16'd35501;
  localparam logic [13:0] COEF_B     = 14'd9568;
  localparam logic [16:0] ONE_Q16    = 17'h10000;
  localparam logic [20:0] X_CLAMP    = 21'h100000;
  localparam logic [15:0] SLOPE_INIT = 16'd256;
  localparam logic [15:0] Y_MAX      = 16'hFFFF;

endpackage

>>> sv/rsig_series.sv
`timescale 1ns / 1ps
// Series stages: scaled magnitude, clamp, powers of x and the sum S ~ e^|x|.
// Five register stages; uses rsig_pkg.
module rsig_series (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  rsig_pkg::in_t       operand,
  input  logic [15:0]         slope,
  output logic                ser_valid,
  output rsig_pkg::ser_t      ser
);

  logic [15:0] raw;
  logic        neg;
  logic        pos;
  logic [15:0] mag;
  logic [31:0] prod;
  logic [27:0] xw;
  logic [20:0] x_c;

  always_comb begin
    raw  = $unsigned(operand.sample_in);
    neg  = raw[15];
    pos  = !neg && (raw != 16'd0);
    mag  = neg ? (16'd0 - raw) : raw;
    prod = 32'(mag) * 32'(slope);
    xw   = prod[31:4];
    x_c  = (xw > 28'(rsig_pkg::X_CLAMP)) ? rsig_pkg::X_CLAMP : xw[20:0];
  end

  // stage 1
  logic        v1;
  logic [20:0] x1;
  logic        pos1, last1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    x1    <= x_c;
    pos1  <= pos;
    last1 <= operand.last_in;
  end

  // stage 2
  logic [41:0] sq;
  logic        v2;
  logic [20:0] x2_x;
  logic [24:0] x2;
  logic        pos2, last2;

  assign sq = 42'(x1) * 42'(x1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    x2_x  <= x1;
    x2    <= sq[40:16];
    pos2  <= pos1;
    last2 <= last1;
  end

  // stage 3
  logic [49:0] x4p;
  logic [40:0] ax2p;
  logic        v3;
  logic [20:0] x3_x;
  logic [32:0] x4;
  logic [24:0] ax2;
  logic        pos3, last3;

  assign x4p  = 50'(x2) * 50'(x2);
  assign ax2p = 41'(rsig_pkg::COEF_A) * 41'(x2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    x3_x  <= x2_x;
    x4    <= x4p[48:16];
    ax2   <= ax2p[40:16];
    pos3  <= pos2;
    last3 <= last2;
  end

  // stage 4
  logic [46:0] bx4p;
  logic        v4;
  logic [29:0] bx4;
  logic [29:0] psum;
  logic        pos4, last4;

  assign bx4p = 47'(rsig_pkg::COEF_B) * 47'(x4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    bx4   <= bx4p[45:16];
    psum  <= 30'(rsig_pkg::ONE_Q16) + 30'(x3_x) + 30'(ax2);
    pos4  <= pos3;
    last4 <= last3;
  end

  // stage 5
  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
    end else begin
      ser_valid <= v4;
    end
    ser.s    <= psum + bx4;
    ser.pos  <= pos4;
    ser.last <= last4;
  end

endmodule

>>> sv/rsig_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: y = round(num / (S + 1.0)), num = S or 1.0 in Q32.
// One setup stage and DIV_STAGES stages of DIV_STEPS quotient bits; uses rsig_pkg.
module rsig_divider (
  input  logic                clk,
  input  logic                rst,
  input  logic                ser_valid,
  input  rsig_pkg::ser_t      ser,
  output logic                quot_valid,
  output rsig_pkg::quot_t     quot
);

  localparam int NS = rsig_pkg::DIV_STAGES;
  localparam int QW = rsig_pkg::Q_W;

  logic [29:0] d0;
  logic [46:0] num;
  logic [46:0] n;

  always_comb begin
    d0  = ser.s + 30'(rsig_pkg::ONE_Q16);
    num = ser.pos ? {1'b0, ser.s, 16'd0} : 47'h1_0000_0000;
    n   = num + 47'(d0[29:1]);
  end

  logic          v    [0:NS];
  logic [29:0]   d    [0:NS];
  logic [29:0]   rem  [0:NS];
  logic [QW-1:0] nlow [0:NS];
  logic [QW-1:0] q    [0:NS];
  logic          last [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= ser_valid;
    end
    d[0]    <= d0;
    rem[0]  <= 30'(n[46:QW]);
    nlow[0] <= n[QW-1:0];
    q[0]    <= '0;
    last[0] <= ser.last;
  end

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [29:0]   r;
    logic [30:0]   t;
    logic [QW-1:0] nl;
    logic [QW-1:0] qq;

    always_comb begin
      r  = rem[g];
      nl = nlow[g];
      qq = q[g];
      t  = '0;
      for (int k = 0; k < rsig_pkg::DIV_STEPS; k++) begin
        t  = {r, nl[QW-1]};
        nl = {nl[QW-2:0], 1'b0};
        if (t >= {1'b0, d[g]}) begin
          t  = t - {1'b0, d[g]};
          qq = {qq[QW-2:0], 1'b1};
        end else begin
          qq = {qq[QW-2:0], 1'b0};
        end
        r = t[29:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else begin
        v[g+1] <= v[g];
      end
      d[g+1]    <= d[g];
      rem[g+1]  <= r;
      nlow[g+1] <= nl;
      q[g+1]    <= qq;
      last[g+1] <= last[g];
    end
  end

  assign quot_valid = v[NS];
  assign quot.q     = q[NS];
  assign quot.last  = last[NS];

endmodule

>>> sv/rough_sigmoid_activation.sv
`timescale 1ns / 1ps
// Rough sigmoid activation: 1 / (1 + e^-(sample*slope)) with a polynomial e^x.
// Fully pipelined through the five series stages and the 2-bit-per-stage divider;
// one transaction per cycle while busy is low.
// Synchronous reset clears all valid bits, sets slope to 1.0 and sets busy, which the
// first edge without reset clears; the receiver cannot stall, so busy is low otherwise.
module rough_sigmoid_activation (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  rsig_pkg::in_t      operand,
  input  logic               slope_we,
  input  logic [15:0]        slope_wdata,
  output logic               done,
  output rsig_pkg::out_t     result
);

  logic            slope_gain;
  logic [15:0]     slope;
  logic            ser_valid;
  rsig_pkg::ser_t  ser;
  logic            quot_valid;
  rsig_pkg::quot_t quot;

  assign slope_gain = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b1;
      slope <= rsig_pkg::SLOPE_INIT;
    end else begin
      busy <= 1'b0;
      if (slope_we) begin
        slope <= slope_wdata;
      end
    end
  end

  rsig_series u_series (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (slope_gain),
    .operand   (operand),
    .slope     (slope),
    .ser_valid (ser_valid),
    .ser       (ser)
  );

  rsig_divider u_divider (
    .clk        (clk),
    .rst        (rst),
    .ser_valid  (ser_valid),
    .ser        (ser),
    .quot_valid (quot_valid),
    .quot       (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= quot_valid;
    end
    result.sigmoid_out <= (quot.q[rsig_pkg::Q_W-1:16] != '0) ? rsig_pkg::Y_MAX
                                                             : quot.q[15:0];
    result.last_out    <= quot.last;
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("done raised right after reset");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##16 done)
    else $error("transaction produced no result");

  a_zero_half: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operand.sample_in == 16'sd0) |-> ##16
    (done && result.sigmoid_out == 16'd32768))
    else $error("zero sample did not give one half");

  a_neg_low: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operand.sample_in[15]) |-> ##16
    (result.sigmoid_out <= 16'd32768))
    else $error("negative sample gave more than one half");

endmodule
